/* rtl/crsp_pkg.sv */
// ----------------------------------------------------------------------------
// Chunk record stream parser package
// Phase, field kind and status codes, frame geometry and field lengths.
// ----------------------------------------------------------------------------
package crsp_pkg;

	localparam int unsigned SECTION_COUNT      = 16;
	localparam int unsigned BLOCKS_PER_SECTION = 4096;

	localparam logic [4:0]  SECTION_LIMIT = 5'(SECTION_COUNT);
	localparam logic [16:0] BLOCK_LIMIT   = 17'(BLOCKS_PER_SECTION);

	typedef logic [3:0] phase_t;
	typedef logic [2:0] kind_t;
	typedef logic [1:0] status_t;

	localparam phase_t PH_MAGIC   = 4'd0;
	localparam phase_t PH_VERSION = 4'd1;
	localparam phase_t PH_FLAGS   = 4'd2;
	localparam phase_t PH_PAD     = 4'd3;
	localparam phase_t PH_X       = 4'd4;
	localparam phase_t PH_Y       = 4'd5;
	localparam phase_t PH_Z       = 4'd6;
	localparam phase_t PH_PCOUNT  = 4'd7;
	localparam phase_t PH_PALETTE = 4'd8;
	localparam phase_t PH_BLOCKS  = 4'd9;

	localparam kind_t KIND_FLAGS   = 3'd0;
	localparam kind_t KIND_X       = 3'd1;
	localparam kind_t KIND_Y       = 3'd2;
	localparam kind_t KIND_Z       = 3'd3;
	localparam kind_t KIND_PCOUNT  = 3'd4;
	localparam kind_t KIND_PALETTE = 3'd5;
	localparam kind_t KIND_BLOCK   = 3'd6;
	localparam kind_t KIND_NONE    = 3'd7;

	localparam status_t ST_OK          = 2'd0;
	localparam status_t ST_BAD_MAGIC   = 2'd1;
	localparam status_t ST_BAD_VERSION = 2'd2;
	localparam status_t ST_TRUNCATED   = 2'd3;

	localparam logic REG_MAGIC   = 1'b0;
	localparam logic REG_VERSION = 1'b1;

	// Number of bytes in the field of a phase, minus one.
	function automatic logic [1:0] phase_last_byte(input phase_t ph);
		logic [1:0] n;
		unique case (ph)
			PH_MAGIC, PH_X, PH_Y, PH_Z:               n = 2'd3;
			PH_VERSION, PH_PCOUNT, PH_PALETTE, PH_BLOCKS: n = 2'd1;
			default:                                  n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

/* rtl/chunk_record_stream_parser.sv */
// ----------------------------------------------------------------------------
// Chunk record stream parser
// Parses a little-endian chunk record byte by byte and emits one result per
// completed field but magic, version or pad; the closing result has the status.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle, back to back. Each accepted byte updates the
// parse state in the same cycle and, if it completes a reported field or closes
// the frame, loads the single output register; results appear in the cycle after
// the byte that causes them. The input stalls only while a result sits in the
// output register and the output side stalls. Write the magic and version
// registers only while the parser is idle.
module chunk_record_stream_parser
	import crsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_write_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  field_kind,
	output logic [3:0]  section_number,
	output logic [15:0] item_index,
	output logic [31:0] field_value,
	output logic        end_of_frame,
	output logic [1:0]  frame_status
);

	logic [31:0] magic_q;
	logic [15:0] version_q;

	phase_t      phase_q,   phase_d;
	logic [1:0]  bif_q,     bif_d;
	logic [31:0] shift_q,   shift_d;
	logic [4:0]  section_q, section_d;
	logic [15:0] pal_rem_q, pal_rem_d;
	logic [15:0] item_q,    item_d;
	logic        closed_q,  closed_d;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [3:0]  sect_q;
	logic [15:0] idx_q;
	logic [31:0] value_q;
	logic        eof_q;
	status_t     status_q;

	logic        in_take;
	logic        res_en;
	kind_t       res_kind;
	logic [3:0]  res_sect;
	logic [15:0] res_idx;
	logic [31:0] res_value;
	logic        res_eof;
	status_t     res_status;

	assign in_stall = out_valid_q & out_stall;
	assign in_take  = in_valid & ~in_stall;

	always_comb begin
		logic [31:0] acc;
		logic        field;
		logic        eof;
		logic [15:0] item_inc;
		logic [4:0]  sect_inc;
		logic [15:0] pal_dec;

		phase_d    = phase_q;
		bif_d      = bif_q;
		shift_d    = shift_q;
		section_d  = section_q;
		pal_rem_d  = pal_rem_q;
		item_d     = item_q;
		closed_d   = closed_q;
		field      = 1'b0;
		eof        = 1'b0;
		res_kind   = KIND_NONE;
		res_sect   = 4'd0;
		res_idx    = 16'd0;
		res_value  = 32'd0;
		res_status = ST_OK;
		item_inc   = item_q + 16'd1;
		sect_inc   = section_q + 5'd1;
		pal_dec    = pal_rem_q - 16'd1;

		case (bif_q)
			2'd0:    acc = shift_q | {24'd0, in_byte};
			2'd1:    acc = shift_q | {16'd0, in_byte, 8'd0};
			2'd2:    acc = shift_q | {8'd0, in_byte, 16'd0};
			default: acc = shift_q | {in_byte, 24'd0};
		endcase

		if (!closed_q) begin
			if (bif_q < phase_last_byte(phase_q)) begin
				shift_d = acc;
				bif_d   = bif_q + 2'd1;
			end else begin
				shift_d = 32'd0;
				bif_d   = 2'd0;
				unique case (phase_q)
					PH_MAGIC: begin
						if (acc != magic_q) begin
							eof        = 1'b1;
							res_status = ST_BAD_MAGIC;
						end else begin
							phase_d = PH_VERSION;
						end
					end
					PH_VERSION: begin
						if (acc[15:0] != version_q) begin
							eof        = 1'b1;
							res_status = ST_BAD_VERSION;
						end else begin
							phase_d = PH_FLAGS;
						end
					end
					PH_FLAGS: begin
						field     = 1'b1;
						res_kind  = KIND_FLAGS;
						res_value = acc;
						phase_d   = PH_PAD;
					end
					PH_PAD: begin
						phase_d = PH_X;
					end
					PH_X, PH_Y, PH_Z: begin
						field     = 1'b1;
						res_kind  = kind_t'(phase_q - PH_X) + KIND_X;
						res_value = acc;
						phase_d   = phase_q + 4'd1;
					end
					PH_PCOUNT: begin
						field     = 1'b1;
						res_kind  = KIND_PCOUNT;
						res_sect  = section_q[3:0];
						res_value = acc;
						pal_rem_d = acc[15:0];
						item_d    = 16'd0;
						phase_d   = (acc[15:0] != 16'd0) ? PH_PALETTE : PH_BLOCKS;
					end
					PH_PALETTE: begin
						field     = 1'b1;
						res_kind  = KIND_PALETTE;
						res_sect  = section_q[3:0];
						res_idx   = item_q;
						res_value = acc;
						item_d    = item_inc;
						pal_rem_d = pal_dec;
						if (pal_dec == 16'd0) begin
							item_d  = 16'd0;
							phase_d = PH_BLOCKS;
						end
					end
					PH_BLOCKS: begin
						field     = 1'b1;
						res_kind  = KIND_BLOCK;
						res_sect  = section_q[3:0];
						res_idx   = item_q;
						res_value = acc;
						item_d    = item_inc;
						if ({1'b0, item_inc} >= BLOCK_LIMIT) begin
							item_d    = 16'd0;
							section_d = sect_inc;
							if (sect_inc >= SECTION_LIMIT) begin
								eof = 1'b1;
							end else begin
								phase_d = PH_PCOUNT;
							end
						end
					end
					default: begin
						// unreachable phase: rearm at the magic
						phase_d = PH_MAGIC;
					end
				endcase
			end
			if (!eof && last_byte) begin
				eof        = 1'b1;
				res_status = ST_TRUNCATED;
			end
			if (eof) begin
				closed_d = 1'b1;
			end
		end

		// last byte of the buffer always rearms the parser
		if (last_byte && (closed_q || eof)) begin
			phase_d   = PH_MAGIC;
			bif_d     = 2'd0;
			shift_d   = 32'd0;
			section_d = 5'd0;
			pal_rem_d = 16'd0;
			item_d    = 16'd0;
			closed_d  = 1'b0;
		end

		res_eof = eof;
		res_en  = in_take & (field | eof);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= 32'd0;
			version_q <= 16'd1;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_MAGIC:   magic_q   <= cfg_data;
				REG_VERSION: version_q <= cfg_data[15:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MAGIC;
			bif_q     <= 2'd0;
			shift_q   <= 32'd0;
			section_q <= 5'd0;
			pal_rem_q <= 16'd0;
			item_q    <= 16'd0;
			closed_q  <= 1'b0;
		end else if (in_take) begin
			phase_q   <= phase_d;
			bif_q     <= bif_d;
			shift_q   <= shift_d;
			section_q <= section_d;
			pal_rem_q <= pal_rem_d;
			item_q    <= item_d;
			closed_q  <= closed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_en) begin
			kind_q   <= res_kind;
			sect_q   <= res_sect;
			idx_q    <= res_idx;
			value_q  <= res_value;
			eof_q    <= res_eof;
			status_q <= res_status;
		end
	end

	assign out_valid      = out_valid_q;
	assign field_kind     = kind_q;
	assign section_number = sect_q;
	assign item_index     = idx_q;
	assign field_value    = value_q;
	assign end_of_frame   = eof_q;
	assign frame_status   = status_q;

	a_status_only_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !eof_q |-> status_q == ST_OK)
		else $error("status set on a result that does not close the frame");

	a_none_only_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_NONE |-> eof_q)
		else $error("empty result that does not close the frame");

	a_section_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!closed_q |-> section_q < SECTION_LIMIT)
		else $error("section counter past the last section in an open frame");

	a_byte_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		bif_q <= phase_last_byte(phase_q))
		else $error("byte position past the end of the field");

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_BLOCKS)
		else $error("parse phase out of range");

endmodule
